// ----- hw/rtl/fbla_pkg.sv -----
package fbla_pkg;

  localparam int unsigned OffsetBits  = 26;
  localparam int unsigned BlockBytesW = 17;
  localparam int unsigned PoolRegW    = 11;
  localparam int unsigned DivCntW     = $clog2(OffsetBits);

  localparam logic [BlockBytesW-1:0] BlockBytesRst = 17'd64;
  localparam logic [PoolRegW-1:0]    PoolRst       = 11'd1024;

  localparam logic FuncAlloc = 1'b0;
  localparam logic FuncFree  = 1'b1;

  localparam logic RegBlockBytes   = 1'b0;
  localparam logic RegBlocksInPool = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_EMPTY      = 2'd1,
    STAT_MISALIGNED = 2'd2,
    STAT_RANGE      = 2'd3
  } status_e;

  typedef struct packed {
    logic                  func;
    logic [OffsetBits-1:0] free_offset;
  } req_t;

  typedef struct packed {
    status_e               status;
    logic [OffsetBits-1:0] block_offset;
  } rsp_t;

  typedef struct packed {
    logic [OffsetBits-1:0]  quot;
    logic [BlockBytesW-1:0] rem;
  } div_res_t;

endpackage

// ----- hw/rtl/fbla_link_ram.sv -----
module fbla_link_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 10
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/fbla_div.sv -----
module fbla_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [fbla_pkg::OffsetBits-1:0]  dividend_i,
  input  logic [fbla_pkg::BlockBytesW-1:0] divisor_i,
  output logic                             done_o,
  output fbla_pkg::div_res_t               res_o
);

  import fbla_pkg::*;

  logic               busy_q, done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [OffsetBits-1:0]  num_q;
  logic [BlockBytesW-1:0] rem_q, dvs_q;

  logic [BlockBytesW:0] shifted, diff;
  logic                 ge;

  assign shifted = {rem_q, num_q[OffsetBits-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DivCntW'(1);
        if (cnt_q == DivCntW'(OffsetBits - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[BlockBytesW-1:0] : shifted[BlockBytesW-1:0];
      num_q <= {num_q[OffsetBits-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign res_o.quot = num_q;
  assign res_o.rem  = rem_q;

endmodule

// ----- hw/rtl/fixed_block_free_list_allocator_unit.sv -----
// Pool allocator for equal-sized blocks. A beat with func 0 allocates: it pops the
// most recently freed block from a linked stack kept in a link memory with separate
// read and write ports (one read), or else hands out the next never-used block in
// rising index order; the result carries the byte offset, block index times
// block_bytes (zero counts as one). A beat with func 1 frees: the offset goes
// through a restoring divider that retires one quotient bit per cycle, one for each
// bit of the 26-bit offset; misaligned or out-of-range frees are reported and leave
// the pool unchanged. One request is in flight at a time; the next is taken while
// the previous result waits in the output register. The link memory needs no
// clearing after reset. The user must see that registers are written through the
// APB port only while the block is idle; the block itself does not enforce this.
module fixed_block_free_list_allocator_unit #(
  parameter int unsigned MAX_BLOCKS = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  fbla_pkg::req_t       in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output fbla_pkg::rsp_t       out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  import fbla_pkg::*;

  localparam int unsigned IdxW  = $clog2(MAX_BLOCKS);
  localparam int unsigned MarkW = $clog2(MAX_BLOCKS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LINK,
    ST_MUL,
    ST_DIV,
    ST_PUSH
  } state_e;

  state_e                 state_q;
  logic [BlockBytesW-1:0] block_bytes_q, bsize_q, bsize;
  logic [PoolRegW-1:0]    blocks_in_pool_q;
  logic [IdxW-1:0]        head_q, idx_q;
  logic                   empty_q;
  logic [MarkW-1:0]       mark_q, pool;
  logic                   out_valid_q;
  rsp_t                   out_q, res_q;

  logic                  in_fire, cfg_wr;
  logic                  div_start, div_done;
  div_res_t              div_res;
  logic [IdxW-1:0]       div_idx;
  logic                  free_ok;
  logic                  mem_we, mem_re;
  logic [IdxW-1:0]       mem_wdata, link_rdata;
  logic [OffsetBits-1:0] prod;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_bytes_q    <= BlockBytesRst;
      blocks_in_pool_q <= PoolRst;
    end else if (cfg_wr) begin
      case (paddr[2])
        RegBlockBytes:   block_bytes_q    <= pwdata[BlockBytesW-1:0];
        RegBlocksInPool: blocks_in_pool_q <= pwdata[PoolRegW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegBlockBytes:   prdata = 32'(block_bytes_q);
      RegBlocksInPool: prdata = 32'(blocks_in_pool_q);
      default:         prdata = '0;
    endcase
  end

  assign bsize = (block_bytes_q == '0) ? BlockBytesW'(1) : block_bytes_q;
  assign pool  = (17'(blocks_in_pool_q) > 17'(MAX_BLOCKS)) ? MarkW'(MAX_BLOCKS)
                                                           : MarkW'(blocks_in_pool_q);

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // offset divider
  assign div_start = in_fire && (in_data_i.func == FuncFree);

  fbla_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (in_data_i.free_offset),
    .divisor_i  (bsize),
    .done_o     (div_done),
    .res_o      (div_res)
  );

  assign div_idx = div_res.quot[IdxW-1:0];
  assign free_ok = (div_res.rem == '0) && (div_res.quot < OffsetBits'(pool));

  // link memory, one access per request so no overlap on an entry
  assign mem_re    = in_fire && (in_data_i.func == FuncAlloc) && !empty_q;
  assign mem_we    = (state_q == ST_DIV) && div_done && free_ok;
  assign mem_wdata = empty_q ? div_idx : head_q;

  fbla_link_ram #(
    .Depth (MAX_BLOCKS),
    .Width (IdxW)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (div_idx),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (head_q),
    .rdata_o (link_rdata)
  );

  assign prod = OffsetBits'(idx_q) * OffsetBits'(bsize_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      empty_q     <= 1'b1;
      mark_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      res_q       <= '0;
      idx_q       <= '0;
      bsize_q     <= '0;
    end else begin
      if ((state_q == ST_PUSH) && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            bsize_q <= bsize;
            if (in_data_i.func == FuncFree) begin
              state_q <= ST_DIV;
            end else if (!empty_q) begin
              idx_q   <= head_q;
              state_q <= ST_LINK;
            end else if (mark_q < pool) begin
              idx_q   <= mark_q[IdxW-1:0];
              mark_q  <= mark_q + MarkW'(1);
              state_q <= ST_MUL;
            end else begin
              res_q   <= '{status: STAT_EMPTY, block_offset: '0};
              state_q <= ST_PUSH;
            end
          end
        end
        ST_LINK: begin
          // bottom of stack links to itself
          if (link_rdata == idx_q) begin
            empty_q <= 1'b1;
          end else begin
            head_q <= link_rdata;
          end
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          res_q   <= '{status: STAT_OK, block_offset: prod};
          state_q <= ST_PUSH;
        end
        ST_DIV: begin
          if (div_done) begin
            if (div_res.rem != '0) begin
              res_q <= '{status: STAT_MISALIGNED, block_offset: '0};
            end else if (!free_ok) begin
              res_q <= '{status: STAT_RANGE, block_offset: '0};
            end else begin
              head_q  <= div_idx;
              empty_q <= 1'b0;
              res_q   <= '{status: STAT_OK, block_offset: '0};
            end
            state_q <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!out_valid_q || out_ready_i) begin
            out_q   <= res_q;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("second request taken while one in flight");

  a_fail_zero_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status != STAT_OK)) |-> (out_data_o.block_offset == '0))
    else $error("failed request carries an offset");

  a_mark_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mark_q <= MarkW'(MAX_BLOCKS))
    else $error("untouched mark beyond pool");

  a_link_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |=> (state_q == ST_LINK))
    else $error("link read without pop");

  a_link_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> (!empty_q && (head_q == $past(div_idx))))
    else $error("push did not update head");

endmodule
